@@ rtl/adcr_pkg.sv @@
// Shared constants and types of the ADC register slave.
package adcr_pkg;

   localparam int ADCR_NUM_CHANNELS = 10;

   // Command codes from the high nibble of a first byte
   localparam logic [3:0] CMD_READ_SHORT   = 4'd2;
   localparam logic [3:0] CMD_STREAM       = 4'd3;
   localparam logic [3:0] CMD_READ_CFG     = 4'd4;
   localparam logic [3:0] CMD_PRESET       = 4'd7;
   localparam logic [3:0] CMD_WRITE_CFG    = 4'd12;
   localparam logic [3:0] CMD_WRITE_GLOBAL = 4'd13;

   localparam logic [4:0] STREAM_LEN    = 5'd20;
   localparam logic [4:0] BLOCK_LEN     = 5'd5;
   localparam logic [2:0] WR_BLOCK_LEN  = 3'd5;
   localparam logic [7:0] RESULT_PRESET = 8'h80;

   // Setup store: address is {global row, channel, byte lane}
   localparam int CFG_ADDR_W = 8;
   localparam int CFG_DEPTH  = 1 << CFG_ADDR_W;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [CFG_ADDR_W-1:0] addr;
      logic [7:0]            wr_data;
   } cfg_access_type;

   // What the response stage needs to build the reply
   typedef struct packed {
      logic       reply_valid;
      logic       cfg_read;
      logic [3:0] nibble;
      logic [4:0] count;
   } stage_type;

endpackage

@@ rtl/adcr_req_if.sv @@
// Request channel: one SPI byte with its first-byte flag.
interface adcr_req_if;
   logic       valid;
   logic       ready;
   logic       first_byte;
   logic [7:0] data_in;

   modport source (output valid, output first_byte, output data_in, input ready);
   modport sink   (input valid, input first_byte, input data_in, output ready);
endinterface

@@ rtl/adcr_rsp_if.sv @@
// Response channel: reply byte, read flag and announced byte count.
interface adcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic       reply_valid;
   logic [4:0] byte_count;

   modport source (output valid, output reply_byte, output reply_valid, output byte_count,
                   input ready);
   modport sink   (input valid, input reply_byte, input reply_valid, input byte_count,
                   output ready);
endinterface

@@ rtl/spi_adc_register_slave.sv @@
// One request per cycle: each SPI byte is accepted whenever the response register is empty or
// being taken, and its response appears in the next cycle, when the registered read port of the
// setup store delivers threshold and setup bytes. A stalled response holds the request side
// for as long as it waits. Setup bytes never written since reset read as zero; no clearing
// pass is needed. Channel results are all zero after reset and all 0x80 after a preset command.
module spi_adc_register_slave
   import adcr_pkg::*;
#(
   parameter int NUM_CHANNELS = ADCR_NUM_CHANNELS
) (
   input  logic       clock,
   input  logic       reset,
   adcr_req_if.sink   req_ch,
   adcr_rsp_if.source rsp_ch
);

   logic           accept;
   logic           stage_valid;
   stage_type      stage;
   cfg_access_type access;
   logic [7:0]     cfg_byte;

   assign req_ch.ready = !stage_valid || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   adcr_ctrl #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .first_byte  (req_ch.first_byte),
      .data_in     (req_ch.data_in),
      .rsp_ready   (rsp_ch.ready),
      .stage_valid (stage_valid),
      .stage       (stage),
      .access      (access)
   );

   adcr_cfg_mem u_cfg_mem (
      .clock   (clock),
      .reset   (reset),
      .access  (access),
      .rd_data (cfg_byte)
   );

   assign rsp_ch.valid       = stage_valid;
   assign rsp_ch.reply_byte  = stage.cfg_read ? cfg_byte : {4'd0, stage.nibble};
   assign rsp_ch.reply_valid = stage.reply_valid;
   assign rsp_ch.byte_count  = stage.count;

   // A first byte never answers with read data
   a_first_no_read: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.first_byte |=> rsp_ch.valid && !rsp_ch.reply_valid)
      else $error("first byte answered with read data");

   // Counts are announced only on first bytes, read data only on later bytes
   a_count_xor_read: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.reply_valid |-> rsp_ch.byte_count == 5'd0)
      else $error("byte count on a read reply");

   // Stream replies carry a single nibble
   a_stream_nibble: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !stage.cfg_read |-> rsp_ch.reply_byte[7:4] == 4'd0)
      else $error("stream reply wider than a nibble");

   // A setup store access is only made for an accepted request
   a_access_accept: assert property (@(posedge clock) disable iff (reset)
      access.wr_en || access.rd_en |-> accept && !(access.wr_en && access.rd_en))
      else $error("setup store accessed without a request");

endmodule

@@ rtl/adcr_cfg_mem.sv @@
// Setup store: per-channel thresholds and setup plus the global setup row.
module adcr_cfg_mem
   import adcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_access_type access,
   output logic [7:0]     rd_data
);

   logic [7:0]           mem_ff [CFG_DEPTH];
   logic [CFG_DEPTH-1:0] written_ff;
   logic [7:0]           rd_data_ff;

   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         mem_ff[access.addr] <= access.wr_data;
      end
   end

   // Never-written bytes read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (access.wr_en) begin
         written_ff[access.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (access.rd_en) begin
         rd_data_ff <= written_ff[access.addr] ? mem_ff[access.addr] : 8'h00;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/adcr_ctrl.sv @@
// Transfer sequencer: command decode, byte counters and response stage.
module adcr_ctrl
   import adcr_pkg::*;
#(
   parameter int NUM_CHANNELS = ADCR_NUM_CHANNELS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           first_byte,
   input  logic [7:0]     data_in,
   input  logic           rsp_ready,
   output logic           stage_valid,
   output stage_type      stage,
   output cfg_access_type access
);

   logic [3:0] cmd_ff, cmd_in;
   logic [3:0] addr_ff, addr_in;
   logic [4:0] read_rem_ff, read_rem_in;
   logic [2:0] write_rem_ff, write_rem_in;
   logic       preset_ff, preset_in;
   logic       stage_valid_ff, stage_valid_in;
   stage_type  stage_ff, stage_in;

   logic [4:0] k;
   logic [3:0] ch;
   logic [2:0] rd_lane;
   logic [2:0] wr_lane;

   assign k       = STREAM_LEN - read_rem_ff;
   assign ch      = k[4:1];
   assign rd_lane = 3'(BLOCK_LEN - read_rem_ff);
   assign wr_lane = WR_BLOCK_LEN - write_rem_ff;

   always_comb begin
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      read_rem_in    = read_rem_ff;
      write_rem_in   = write_rem_ff;
      preset_in      = preset_ff;
      stage_in       = '0;
      access         = '0;
      stage_valid_in = stage_valid_ff && !rsp_ready;

      if (accept) begin
         stage_valid_in = 1'b1;
         if (first_byte) begin
            cmd_in  = data_in[7:4];
            addr_in = data_in[3:0];
            case (data_in[7:4])
               CMD_READ_SHORT, CMD_READ_CFG: begin
                  stage_in.count = BLOCK_LEN;
                  read_rem_in    = BLOCK_LEN;
               end
               CMD_STREAM: begin
                  stage_in.count = STREAM_LEN;
                  read_rem_in    = STREAM_LEN;
               end
               CMD_PRESET: begin
                  preset_in = 1'b1;
               end
               CMD_WRITE_CFG, CMD_WRITE_GLOBAL: begin
                  write_rem_in = WR_BLOCK_LEN;
               end
               default: begin
               end
            endcase
         end else begin
            case (cmd_ff)
               CMD_STREAM: begin
                  if (read_rem_ff != 5'd0 && read_rem_ff <= STREAM_LEN) begin
                     stage_in.reply_valid = 1'b1;
                     // All results hold either zero or the preset value
                     if ({1'b0, ch} < 5'(NUM_CHANNELS) && preset_ff) begin
                        stage_in.nibble = k[0] ? RESULT_PRESET[3:0] : RESULT_PRESET[7:4];
                     end
                     read_rem_in = read_rem_ff - 5'd1;
                  end
               end
               CMD_READ_CFG: begin
                  if (read_rem_ff != 5'd0 && read_rem_ff <= BLOCK_LEN) begin
                     stage_in.reply_valid = 1'b1;
                     stage_in.cfg_read    = 1'b1;
                     access.rd_en         = 1'b1;
                     access.addr          = {1'b0, addr_ff, rd_lane};
                     read_rem_in          = read_rem_ff - 5'd1;
                  end
               end
               CMD_WRITE_CFG, CMD_WRITE_GLOBAL: begin
                  if (write_rem_ff != 3'd0 && write_rem_ff <= WR_BLOCK_LEN) begin
                     access.wr_en   = 1'b1;
                     access.wr_data = data_in;
                     access.addr    = (cmd_ff == CMD_WRITE_GLOBAL) ?
                                      {1'b1, 4'd0, wr_lane} : {1'b0, addr_ff, wr_lane};
                     write_rem_in   = write_rem_ff - 3'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff         <= '0;
         addr_ff        <= '0;
         read_rem_ff    <= '0;
         write_rem_ff   <= '0;
         preset_ff      <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         cmd_ff         <= cmd_in;
         addr_ff        <= addr_in;
         read_rem_ff    <= read_rem_in;
         write_rem_ff   <= write_rem_in;
         preset_ff      <= preset_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Hold the response payload until the next request is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule
